// ===== hw/rtl/thermal_false_color_map_core_macros.svh =====
// Assertion helpers for the false color map core.
`ifndef THERMAL_FALSE_COLOR_MAP_CORE_MACROS_SVH
`define THERMAL_FALSE_COLOR_MAP_CORE_MACROS_SVH

// Same-cycle implication, gated by reset.
`define TFCM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, gated by reset.
`define TFCM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/tfcm_pkg.sv =====
`timescale 1ns / 1ps

package tfcm_pkg;

   localparam int TEMP_WIDTH = 16;

   // stream and register port widths
   localparam int IN_DATA_W  = ((TEMP_WIDTH + 7) / 8) * 8;
   localparam int OUT_DATA_W = 24;
   localparam int CODE_W     = 2;
   localparam int FRAC_W     = 9;
   localparam int CSR_W      = (TEMP_WIDTH > FRAC_W) ? TEMP_WIDTH : FRAC_W;
   localparam int CSR_IDX_W  = 3;

   // datapath widths
   localparam int NUM_W  = TEMP_WIDTH + 1;
   localparam int HUE_W  = 9;
   localparam int DIV_W  = NUM_W + HUE_W;
   localparam int DIV_STEPS = HUE_W;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_HUE_FLOOR  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HOT_LIMIT  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_COLD_CUT   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_SATURATION = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_BRIGHTNESS = 3'd4;

   // range codes
   localparam logic [CODE_W-1:0] RANGE_HUE  = 2'd0;
   localparam logic [CODE_W-1:0] RANGE_COLD = 2'd1;
   localparam logic [CODE_W-1:0] RANGE_HOT  = 2'd2;

   // register reset values
   localparam logic signed [TEMP_WIDTH-1:0] RST_HUE_FLOOR = TEMP_WIDTH'(224);
   localparam logic signed [TEMP_WIDTH-1:0] RST_HOT_LIMIT = TEMP_WIDTH'(640);
   localparam logic signed [TEMP_WIDTH-1:0] RST_COLD_CUT  = TEMP_WIDTH'(176);
   localparam logic [FRAC_W-1:0] FRAC_ONE = 9'd256;

   // fixed colors
   localparam logic [7:0] COLD_RG   = 8'd30;
   localparam logic [7:0] COLD_B    = 8'd50;
   localparam logic [7:0] FULL_BYTE = 8'd255;

   localparam int HUE_SPAN = 300;
   localparam int SECTOR_DEG = 60;

endpackage

// ===== hw/rtl/thermal_false_color_map_core.sv =====
`timescale 1ns / 1ps
// Channel   Dir   Payload
// req_      in    tdata[15:0] sample_temp (signed)
// rsp_      out   tdata[23:0] chan_first, chan_second, chan_third; tuser[1:0] range_code
// csr_      in    csr_index selects register, csr_data holds the value
//
// One sample per cycle while the result is not stalled.
// The pipeline is the nine one-bit stages of the hue divider plus the
// range, dividend, sector, product, reciprocal and select stages around it.
// Reset (synchronous, high) empties the pipeline and loads register defaults.
// A stalled result freezes every stage; req_tready drops only then.
// csr_ready is always high.

module thermal_false_color_map_core
   import tfcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,    // [15:0] sample_temp
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,    // [7:0] first, [15:8] second, [23:16] third
   output logic [CODE_W-1:0]     rsp_tuser,    // [1:0] range_code
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data
);

   // ---------------- configuration ----------------
   logic signed [TEMP_WIDTH-1:0] floor_ff, hot_ff, cold_ff;
   logic [FRAC_W-1:0]            sat_ff, bri_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         floor_ff <= RST_HUE_FLOOR;
         hot_ff   <= RST_HOT_LIMIT;
         cold_ff  <= RST_COLD_CUT;
         sat_ff   <= FRAC_ONE;
         bri_ff   <= FRAC_ONE;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_HUE_FLOOR:  floor_ff <= signed'(csr_data[TEMP_WIDTH-1:0]);
            REG_HOT_LIMIT:  hot_ff   <= signed'(csr_data[TEMP_WIDTH-1:0]);
            REG_COLD_CUT:   cold_ff  <= signed'(csr_data[TEMP_WIDTH-1:0]);
            REG_SATURATION: sat_ff   <= csr_data[FRAC_W-1:0];
            REG_BRIGHTNESS: bri_ff   <= csr_data[FRAC_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances together
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   // ---------------- stage 1: range test, span ----------------
   logic signed [TEMP_WIDTH-1:0] t_s, tt_s;
   logic signed [NUM_W-1:0]      num_s, den_s;
   logic                         span_s;
   logic [CODE_W-1:0]            code1_in;

   logic                 vld1_ff;
   logic [CODE_W-1:0]    code1_ff;
   logic [NUM_W-1:0]     num1_ff, den1_ff;

   always_comb begin
      t_s    = signed'(req_tdata[TEMP_WIDTH-1:0]);
      tt_s   = (t_s > floor_ff) ? t_s : floor_ff;
      span_s = hot_ff > floor_ff;
      num_s  = {tt_s[TEMP_WIDTH-1], tt_s} - {floor_ff[TEMP_WIDTH-1], floor_ff};
      den_s  = {hot_ff[TEMP_WIDTH-1], hot_ff} - {floor_ff[TEMP_WIDTH-1], floor_ff};
      if (t_s <= cold_ff)
         code1_in = RANGE_COLD;
      else if (t_s > hot_ff)
         code1_in = RANGE_HOT;
      else
         code1_in = RANGE_HUE;
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld1_ff <= 1'b0;
      else if (adv)
         vld1_ff <= req_tvalid;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code1_ff <= code1_in;
         // empty span: zero numerator over unit divisor gives hue zero
         num1_ff  <= span_s ? unsigned'(num_s) : '0;
         den1_ff  <= span_s ? unsigned'(den_s) : NUM_W'(1);
      end
   end

   // ---------------- stage 2 and divider stages ----------------
   // index 0 holds the scaled dividend, index k the state after k quotient bits
   logic                 d_vld_ff  [0:DIV_STEPS];
   logic [CODE_W-1:0]    d_code_ff [0:DIV_STEPS];
   logic [DIV_W-1:0]     d_rem_ff  [0:DIV_STEPS];
   logic [HUE_W-1:0]     d_quo_ff  [0:DIV_STEPS];
   logic [NUM_W-1:0]     d_den_ff  [0:DIV_STEPS];

   logic [DIV_W-1:0]     d_rem_in  [1:DIV_STEPS];
   logic [HUE_W-1:0]     d_quo_in  [1:DIV_STEPS];

   always_comb begin
      logic [DIV_W-1:0] shifted;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         shifted     = DIV_W'(d_den_ff[j-1]) << (DIV_STEPS - j);
         d_rem_in[j] = d_rem_ff[j-1];
         d_quo_in[j] = d_quo_ff[j-1];
         if (d_rem_ff[j-1] >= shifted) begin
            d_rem_in[j] = d_rem_ff[j-1] - shifted;
            d_quo_in[j][DIV_STEPS - j] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STEPS; j++)
            d_vld_ff[j] <= 1'b0;
      end else if (adv) begin
         d_vld_ff[0] <= vld1_ff;
         for (int j = 1; j <= DIV_STEPS; j++)
            d_vld_ff[j] <= d_vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         d_code_ff[0] <= code1_ff;
         d_rem_ff[0]  <= DIV_W'(num1_ff) * DIV_W'(HUE_SPAN);
         d_quo_ff[0]  <= '0;
         d_den_ff[0]  <= den1_ff;
         for (int j = 1; j <= DIV_STEPS; j++) begin
            d_code_ff[j] <= d_code_ff[j-1];
            d_rem_ff[j]  <= d_rem_in[j];
            d_quo_ff[j]  <= d_quo_in[j];
            d_den_ff[j]  <= d_den_ff[j-1];
         end
      end
   end

   // ---------------- stage 12: sector and offset ----------------
   // in the hue range the quotient never exceeds the span, so no wrap at 360 is needed
   logic [HUE_W-1:0] hue_s;
   logic [2:0]       sec_in;
   logic [HUE_W-1:0] base_s;

   logic             vld12_ff;
   logic [CODE_W-1:0] code12_ff;
   logic [2:0]       sec12_ff;
   logic [5:0]       rem12_ff;

   always_comb begin
      hue_s = d_quo_ff[DIV_STEPS];
      if (hue_s >= HUE_W'(5 * SECTOR_DEG))      sec_in = 3'd5;
      else if (hue_s >= HUE_W'(4 * SECTOR_DEG)) sec_in = 3'd4;
      else if (hue_s >= HUE_W'(3 * SECTOR_DEG)) sec_in = 3'd3;
      else if (hue_s >= HUE_W'(2 * SECTOR_DEG)) sec_in = 3'd2;
      else if (hue_s >= HUE_W'(SECTOR_DEG))     sec_in = 3'd1;
      else                                      sec_in = 3'd0;
      base_s = HUE_W'(sec_in) * HUE_W'(SECTOR_DEG);
   end

   always_ff @(posedge clock) begin
      if (reset)
         vld12_ff <= 1'b0;
      else if (adv)
         vld12_ff <= d_vld_ff[DIV_STEPS];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code12_ff <= d_code_ff[DIV_STEPS];
         sec12_ff  <= sec_in;
         rem12_ff  <= 6'(hue_s - base_s);
      end
   end

   // ---------------- stage 13: first products ----------------
   logic [FRAC_W-1:0] s_eff, v_eff;

   logic              vld13_ff;
   logic [CODE_W-1:0] code13_ff;
   logic [2:0]        sec13_ff;
   logic [15:0]       a13_ff;      // 255 * v
   logic [13:0]       sq13_ff;     // s * rem
   logic [13:0]       st13_ff;     // s * (60 - rem)
   logic [FRAC_W-1:0] ps13_ff;     // 256 - s

   assign s_eff = (sat_ff > FRAC_ONE) ? FRAC_ONE : sat_ff;
   assign v_eff = (bri_ff > FRAC_ONE) ? FRAC_ONE : bri_ff;

   always_ff @(posedge clock) begin
      if (reset)
         vld13_ff <= 1'b0;
      else if (adv)
         vld13_ff <= vld12_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code13_ff <= code12_ff;
         sec13_ff  <= sec12_ff;
         a13_ff    <= 16'(16'(v_eff) * 16'd255);
         sq13_ff   <= 14'(15'(s_eff) * 15'(rem12_ff));
         st13_ff   <= 14'(15'(s_eff) * 15'(6'(SECTOR_DEG) - rem12_ff));
         ps13_ff   <= FRAC_ONE - s_eff;
      end
   end

   // ---------------- stage 14: channel products ----------------
   logic              vld14_ff;
   logic [CODE_W-1:0] code14_ff;
   logic [2:0]        sec14_ff;
   logic [29:0]       mq14_ff, mt14_ff;
   logic [23:0]       mp14_ff;
   logic [7:0]        cv14_ff;

   always_ff @(posedge clock) begin
      if (reset)
         vld14_ff <= 1'b0;
      else if (adv)
         vld14_ff <= vld13_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         code14_ff <= code13_ff;
         sec14_ff  <= sec13_ff;
         mq14_ff   <= 30'(a13_ff) * 30'(14'd15360 - sq13_ff);
         mt14_ff   <= 30'(a13_ff) * 30'(14'd15360 - st13_ff);
         mp14_ff   <= 24'(25'(a13_ff) * 25'(ps13_ff));
         cv14_ff   <= a13_ff[15:8];
      end
   end

   // ---------------- stage 15: divide by 60 estimate ----------------
   // floor(y/60) for y <= 15300: (y*1092)>>16 is exact or one low
   logic [13:0]       yq_s, yt_s;

   logic              vld15_ff;
   logic [CODE_W-1:0] code15_ff;
   logic [2:0]        sec15_ff;
   logic [13:0]       yq15_ff, yt15_ff;
   logic [8:0]        eq15_ff, et15_ff;
   logic [7:0]        cp15_ff, cv15_ff;

   assign yq_s = mq14_ff[29:16];
   assign yt_s = mt14_ff[29:16];

   always_ff @(posedge clock) begin
      if (reset)
         vld15_ff <= 1'b0;
      else if (adv)
         vld15_ff <= vld14_ff;
   end

   always_ff @(posedge clock) begin
      logic [24:0] pq, pt;
      pq = 25'(yq_s) * 25'd1092;
      pt = 25'(yt_s) * 25'd1092;
      if (adv) begin
         code15_ff <= code14_ff;
         sec15_ff  <= sec14_ff;
         yq15_ff   <= yq_s;
         yt15_ff   <= yt_s;
         eq15_ff   <= pq[24:16];
         et15_ff   <= pt[24:16];
         cp15_ff   <= mp14_ff[23:16];
         cv15_ff   <= cv14_ff;
      end
   end

   // ---------------- stage 16: correct, select, output ----------------
   logic [7:0] cq_s, ct_s;
   logic [7:0] r_s, g_s, b_s;

   always_comb begin
      logic [13:0] rq, rt;
      rq   = yq15_ff - 14'(14'(eq15_ff) * 14'(SECTOR_DEG));
      rt   = yt15_ff - 14'(14'(et15_ff) * 14'(SECTOR_DEG));
      cq_s = (rq >= 14'(SECTOR_DEG)) ? 8'(eq15_ff + 9'd1) : eq15_ff[7:0];
      ct_s = (rt >= 14'(SECTOR_DEG)) ? 8'(et15_ff + 9'd1) : et15_ff[7:0];
      case (sec15_ff)
         3'd1: begin r_s = cq_s;    g_s = cv15_ff; b_s = cp15_ff; end
         3'd2: begin r_s = cp15_ff; g_s = cv15_ff; b_s = ct_s;    end
         3'd3: begin r_s = cp15_ff; g_s = cq_s;    b_s = cv15_ff; end
         3'd4: begin r_s = ct_s;    g_s = cp15_ff; b_s = cv15_ff; end
         3'd5: begin r_s = cv15_ff; g_s = cp15_ff; b_s = cq_s;    end
         default: begin r_s = cv15_ff; g_s = ct_s; b_s = cp15_ff; end
      endcase
      case (code15_ff)
         RANGE_COLD: begin r_s = COLD_RG;   g_s = COLD_RG;   b_s = COLD_B;    end
         RANGE_HOT:  begin r_s = FULL_BYTE; g_s = FULL_BYTE; b_s = FULL_BYTE; end
         default: ;
      endcase
   end

   logic                  out_vld_ff;
   logic [OUT_DATA_W-1:0] out_data_ff;
   logic [CODE_W-1:0]     out_code_ff;

   always_ff @(posedge clock) begin
      if (reset)
         out_vld_ff <= 1'b0;
      else if (adv)
         out_vld_ff <= vld15_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_data_ff <= {b_s, g_s, r_s};
         out_code_ff <= code15_ff;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_code_ff;

endmodule

// ===== hw/rtl/tfcm_checker.sv =====
`timescale 1ns / 1ps
`include "thermal_false_color_map_core_macros.svh"

module tfcm_checker
   import tfcm_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic [IN_DATA_W-1:0]  req_tdata,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [OUT_DATA_W-1:0] rsp_tdata,
   input logic [CODE_W-1:0]     rsp_tuser
);

   // held result must not change under back-pressure
   `TFCM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result changed while stalled")

   // input side only backs up when the result is stuck
   `TFCM_ASSERT_NOW(a_ready_stall, clock, reset, !req_tready,
      rsp_tvalid && !rsp_tready, "input stalled without output stall")

   `TFCM_ASSERT_NOW(a_code_legal, clock, reset, rsp_tvalid,
      rsp_tuser <= RANGE_HOT, "bad range code")

   `TFCM_ASSERT_NOW(a_cold_color, clock, reset, rsp_tvalid && (rsp_tuser == RANGE_COLD),
      rsp_tdata == {COLD_B, COLD_RG, COLD_RG}, "cold color wrong")

   `TFCM_ASSERT_NOW(a_hot_color, clock, reset, rsp_tvalid && (rsp_tuser == RANGE_HOT),
      rsp_tdata == {FULL_BYTE, FULL_BYTE, FULL_BYTE}, "hot color wrong")

endmodule

bind thermal_false_color_map_core tfcm_checker u_tfcm_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== tb/color_map_monitor.sv =====
`timescale 1ns / 1ps

module color_map_monitor
   import tfcm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [IN_DATA_W-1:0]  req_tdata,    // [15:0] sample_temp
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [OUT_DATA_W-1:0] rsp_tdata,    // [7:0] first, [15:8] second, [23:16] third
   input  logic [CODE_W-1:0]     rsp_tuser,    // [1:0] range_code
   input  logic                  csr_valid,
   input  logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_data,
   output int                    fail_count,
   output int                    pending
);

   typedef struct packed {
      logic [7:0]        chan_first;
      logic [7:0]        chan_second;
      logic [7:0]        chan_third;
      logic [CODE_W-1:0] range_code;
   } pixel_color_type;

   // shadow copy of the register file
   logic signed [TEMP_WIDTH-1:0] floor_temp;
   logic signed [TEMP_WIDTH-1:0] hot_temp;
   logic signed [TEMP_WIDTH-1:0] cold_temp;
   logic [FRAC_W-1:0]            sat_q8;
   logic [FRAC_W-1:0]            val_q8;

   pixel_color_type color_queue[$];
   pixel_color_type want_color;
   int              errors = 0;

   assign fail_count = errors;

   function automatic pixel_color_type map_temp_to_color(logic signed [TEMP_WIDTH-1:0] sample);
      pixel_color_type c;
      longint t, fl, hot, cold, s, v, hue, sector, rem;
      longint cv, cp, cq, ct, r, g, b;
      t    = sample;
      fl   = floor_temp;
      hot  = hot_temp;
      cold = cold_temp;
      if (t <= cold) begin
         r = COLD_RG;
         g = COLD_RG;
         b = COLD_B;
         c.range_code = RANGE_COLD;
      end else if (t > hot) begin
         r = FULL_BYTE;
         g = FULL_BYTE;
         b = FULL_BYTE;
         c.range_code = RANGE_HOT;
      end else begin
         // Q1.8 inputs clip at one
         s = (sat_q8 > FRAC_ONE) ? FRAC_ONE : sat_q8;
         v = (val_q8 > FRAC_ONE) ? FRAC_ONE : val_q8;
         hue = 0;
         if (hot > fl)
            hue = (HUE_SPAN * ((t > fl ? t : fl) - fl)) / (hot - fl);
         hue    = hue % 360;
         sector = hue / SECTOR_DEG;
         rem    = hue % SECTOR_DEG;
         // exact rational products, truncated once
         cv = (255 * v) / 256;
         cp = (255 * v * (256 - s)) / 65536;
         cq = (255 * v * (15360 - s * rem)) / 3932160;
         ct = (255 * v * (15360 - s * (SECTOR_DEG - rem))) / 3932160;
         case (sector)
            1: begin r = cq; g = cv; b = cp; end
            2: begin r = cp; g = cv; b = ct; end
            3: begin r = cp; g = cq; b = cv; end
            4: begin r = ct; g = cp; b = cv; end
            5: begin r = cv; g = cp; b = cq; end
            default: begin r = cv; g = ct; b = cp; end
         endcase
         c.range_code = RANGE_HUE;
      end
      c.chan_first  = 8'(r);
      c.chan_second = 8'(g);
      c.chan_third  = 8'(b);
      return c;
   endfunction

   task automatic check_field(string field, int want, int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", field, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         floor_temp <= RST_HUE_FLOOR;
         hot_temp   <= RST_HOT_LIMIT;
         cold_temp  <= RST_COLD_CUT;
         sat_q8     <= FRAC_ONE;
         val_q8     <= FRAC_ONE;
         color_queue.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_HUE_FLOOR:  floor_temp <= csr_data[TEMP_WIDTH-1:0];
               REG_HOT_LIMIT:  hot_temp   <= csr_data[TEMP_WIDTH-1:0];
               REG_COLD_CUT:   cold_temp  <= csr_data[TEMP_WIDTH-1:0];
               REG_SATURATION: sat_q8     <= csr_data[FRAC_W-1:0];
               REG_BRIGHTNESS: val_q8     <= csr_data[FRAC_W-1:0];
               default: ;
            endcase
         end
         // compare before queueing: a result never belongs to a sample taken in the same cycle
         if (rsp_tvalid && rsp_tready) begin
            if (color_queue.size() == 0) begin
               $error("result transfer with nothing pending: tdata=%h tuser=%h",
                      rsp_tdata, rsp_tuser);
               errors++;
            end else begin
               want_color = color_queue[0];
               color_queue.delete(0);
               check_field("chan_first",  want_color.chan_first,  rsp_tdata[7:0]);
               check_field("chan_second", want_color.chan_second, rsp_tdata[15:8]);
               check_field("chan_third",  want_color.chan_third,  rsp_tdata[23:16]);
               check_field("range_code",  want_color.range_code,  rsp_tuser);
            end
         end
         if (req_tvalid && req_tready)
            color_queue.insert(color_queue.size(),
                               map_temp_to_color(req_tdata[TEMP_WIDTH-1:0]));
      end
      pending = color_queue.size();
   end

endmodule

// ===== tb/thermal_false_color_map_core_test.sv =====
`timescale 1ns / 1ps

module thermal_false_color_map_core_test;
   import tfcm_pkg::*;

   localparam int RESET_CYCLES     = 10;
   localparam int SETTLE_CYCLES    = 24;
   localparam int LONG_HOLD_CYCLES = 60;
   localparam int PHASES           = 8;
   localparam int CHUNKS           = 3;
   localparam int CHUNK_ITEMS      = 25;
   localparam int FULL_HOLD_PHASE  = 4;

   typedef logic signed [TEMP_WIDTH-1:0] temp_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [IN_DATA_W-1:0]  req_tdata  = '0;      // [15:0] sample_temp
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b1;
   logic [OUT_DATA_W-1:0] rsp_tdata;            // [7:0] first, [15:8] second, [23:16] third
   logic [CODE_W-1:0]     rsp_tuser;            // [1:0] range_code
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_W-1:0]      csr_data   = '0;

   int fail_count;
   int pending;
   bit gaps_on   = 1'b0;
   bit stalls_on = 1'b0;
   bit long_hold = 1'b0;

   // boundaries of the reset-value ranges, sector edges, full-scale and bit patterns
   temp_type corner_temps[21] = '{-32768, 32767, 0, -1, 175, 176, 177, 223, 224, 225, 307,
                                  308, 400, 480, 560, 630, 639, 640, 641, 21845, -21846};

   thermal_false_color_map_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   color_map_monitor u_monitor (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAIL thermal_false_color_map_core");
      $finish;
   end

   // result side: random short stalls, or one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (long_hold) begin
            long_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
            rsp_tready <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clock);
            rsp_tready <= 1'b1;
         end
      end
   end

   function automatic temp_type clamp_temp(longint x);
      if (x < -32768) return temp_type'(-32768);
      if (x > 32767)  return temp_type'(32767);
      return temp_type'(x);
   endfunction

   // mostly around the configured ranges, some over the full 16-bit span
   function automatic temp_type pick_temp(longint lo, longint hi);
      if ($urandom_range(0, 9) < 7)
         return clamp_temp(lo + longint'($urandom_range(0, int'(hi - lo))));
      return temp_type'($urandom);
   endfunction

   // called at a clock edge; returns at the edge of the transfer
   task automatic send_temp(temp_type sample);
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= IN_DATA_W'(unsigned'(sample));
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic load_config(temp_type fl, temp_type hot, temp_type cold, int sat,
                              int bright);
      logic [CSR_W-1:0] junk;
      junk = CSR_W'($urandom) << FRAC_W;
      write_reg(REG_HUE_FLOOR, fl);
      write_reg(REG_HOT_LIMIT, hot);
      write_reg(REG_COLD_CUT, cold);
      // upper bits above the Q1.8 field must be dropped
      write_reg(REG_SATURATION, junk | CSR_W'(sat));
      write_reg(REG_BRIGHTNESS, (CSR_W'($urandom) << FRAC_W) | CSR_W'(bright));
      // unmapped index, must have no effect
      write_reg(CSR_IDX_W'(REG_BRIGHTNESS + $urandom_range(1, 3)), CSR_W'($urandom));
      csr_valid <= 1'b0;
   endtask

   initial begin
      longint fl, hot, cold, lo, hi;
      int     sat, bright;
      bit     last_phase;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // corners under the reset register values
      foreach (corner_temps[i]) send_temp(corner_temps[i]);
      wait_idle();

      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin fl = -32768; hot = 32767; cold = -32768; sat = 256; bright = 256; end
            1: begin fl = 0;      hot = 360;   cold = -100;   sat = 0;   bright = 0;   end
            // empty hue span, over-range saturation and value
            2: begin fl = 500;    hot = 100;   cold = -500;   sat = 511; bright = 511; end
            // cold cutoff above hot limit
            3: begin fl = -200;   hot = 200;   cold = 1000;   sat = 128; bright = 300; end
            default: begin
               fl     = longint'($urandom_range(0, 6000)) - 3000;
               hot    = fl + longint'($urandom_range(1, 3000));
               cold   = fl + longint'($urandom_range(0, 600)) - 300;
               sat    = $urandom_range(0, 511);
               bright = $urandom_range(0, 511);
            end
         endcase
         load_config(clamp_temp(fl), clamp_temp(hot), clamp_temp(cold), sat, bright);
         lo = ((cold < fl) ? cold : fl) - 50;
         hi = ((hot > cold) ? hot : cold) + 50;
         last_phase = (phase == PHASES - 1);

         if (phase == FULL_HOLD_PHASE) begin
            // receiver holds off while samples keep coming, to back up the pipeline
            @(negedge clock) long_hold = 1'b1;
            @(posedge clock);
         end

         for (int chunk = 0; chunk < CHUNKS; chunk++) begin
            gaps_on   = !last_phase && !(phase == FULL_HOLD_PHASE && chunk == 0) &&
                        ($urandom_range(0, 3) != 0);
            stalls_on = !last_phase && ($urandom_range(0, 3) != 0);
            repeat (CHUNK_ITEMS) send_temp(pick_temp(lo, hi));
         end
         wait_idle();
      end

      stalls_on = 1'b0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("PASS thermal_false_color_map_core");
      else
         $display("FAIL thermal_false_color_map_core");
      $finish;
   end

endmodule

// ===== thermal_false_color_map_core.f =====
+incdir+hw/rtl
hw/rtl/tfcm_pkg.sv
hw/rtl/thermal_false_color_map_core.sv
hw/rtl/tfcm_checker.sv
tb/color_map_monitor.sv
tb/thermal_false_color_map_core_test.sv
